>>> design/ple_pkg.sv
// shared types, constants and codes of the positional list engine
package ple_pkg;

  localparam int CAPACITY = 16;

  // widths of the request and result fields
  localparam int CMD_W = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  // count holds 0..CAPACITY, an index 0..CAPACITY-1
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // width for comparing positions against the count
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int IN_W  = CMD_W + POS_W + VAL_W;
  localparam int IN_TW = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W  = VAL_W + CNT_W + ST_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_REMOVE_AT  = 3'd5,
    CMD_READ_AT    = 3'd6
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // decoded operation handed from control to the store
  typedef struct packed {
    logic              ins;   // open a slot at idx
    logic              rem;   // close the slot at idx
    logic              rd;    // result comes from entry idx
    logic [IDX_W-1:0]  idx;
    status_t           status;
  } ple_op_t;

endpackage

>>> design/ple_ctrl.sv
// command decode: target slot, status and store operation
module ple_ctrl import ple_pkg::*; (
  input  logic [CMD_W-1:0] cmd,
  input  logic [POS_W-1:0] position,
  input  logic [CNT_W-1:0] count,
  output ple_op_t          op
);

  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] at;
  logic             is_ins;
  logic             is_rem;
  logic             is_rd;
  logic             full;

  assign cnt_x = CMP_W'(count);
  assign pos_x = CMP_W'(position);
  assign full  = (count >= CNT_W'(CAPACITY));

  always_comb begin
    at     = '0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    is_rd  = 1'b0;
    case (cmd_t'(cmd))
      CMD_PUSH_FRONT: begin
        is_ins = 1'b1;
      end
      CMD_PUSH_BACK: begin
        is_ins = 1'b1;
        at     = cnt_x;
      end
      CMD_INSERT_AT: begin
        is_ins = 1'b1;
        at     = pos_x;
      end
      CMD_POP_FRONT: begin
        is_rem = 1'b1;
      end
      CMD_POP_BACK: begin
        is_rem = 1'b1;
        at     = cnt_x - CMP_W'(1);
      end
      CMD_REMOVE_AT: begin
        is_rem = 1'b1;
        at     = pos_x;
      end
      CMD_READ_AT: begin
        is_rd = 1'b1;
        at    = pos_x;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    op        = '0;
    op.idx    = at[IDX_W-1:0];
    op.status = ST_OK;
    if (is_ins) begin
      if (at > cnt_x) begin
        op.status = ST_BADPOS;
      end else if (full) begin
        op.status = ST_FULL;
      end else begin
        op.ins = 1'b1;
      end
    end else if (is_rem || is_rd) begin
      if (count == '0) begin
        op.status = ST_EMPTY;
      end else if (at >= cnt_x) begin
        op.status = ST_BADPOS;
      end else begin
        op.rem = is_rem;
        op.rd  = 1'b1;
      end
    end
  end

endmodule

>>> design/ple_store.sv
// register array of entries with parallel shift and the element count
module ple_store import ple_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ple_op_t          op,
  input  logic [VAL_W-1:0] value,
  output logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0] count_next,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] entries      [CAPACITY];
  logic [VAL_W-1:0] entries_next [CAPACITY];

  assign rd_data = entries[op.idx];

  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + CNT_W'(1);
    end else if (op.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic [VAL_W-1:0] from_below;
    logic [VAL_W-1:0] from_above;

    if (i == 0) begin : g_lo
      assign from_below = entries[i];
    end else begin : g_mid
      assign from_below = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign from_above = entries[i];
    end else begin : g_up
      assign from_above = entries[i+1];
    end

    always_comb begin
      entries_next[i] = entries[i];
      if (op.ins) begin
        if (IDX_W'(i) == op.idx) begin
          entries_next[i] = value;
        end else if (IDX_W'(i) > op.idx) begin
          entries_next[i] = from_below;
        end
      end else if (op.rem && (IDX_W'(i) >= op.idx)) begin
        entries_next[i] = from_above;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (en) begin
      count <= count_next;
    end
  end

endmodule

>>> design/positional_list_engine_core.sv
// top level of the positional list engine: request and result registers around the store
//
// bounded positional list of up to CAPACITY signed 32-bit words. each request
// pushes or pops at either end, inserts or removes at a position, or reads at a
// position, and returns exactly one result: the removed or read word (zero
// otherwise), the count after the request and a status (ok, empty, bad position,
// full). a request that fails its check leaves the list untouched. one request
// is taken every cycle while the result stream does not stall; each passes the
// request register and then the result register. the rate is set by the entry
// array, which shifts all words by index compare in the same cycle the request
// is decoded. there is no clearing pass after reset: only the count is cleared.
module positional_list_engine_core import ple_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // request stream
  input  logic              s_tvalid,
  output logic              s_tready,
  // command [2:0], position [7:3], value [39:8]
  input  logic [IN_TW-1:0]  s_tdata,
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // result_value [31:0], count [36:32], status [38:37], zero fill above
  output logic [OUT_TW-1:0] m_tdata
);

  // request register
  logic             in_valid;
  logic [CMD_W-1:0] in_cmd;
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;

  // result register
  logic [VAL_W-1:0] res_value;
  logic [CNT_W-1:0] res_count;
  status_t          res_status;

  logic             fire;
  ple_op_t          op;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [VAL_W-1:0] rd_data;
  ple_op_t          op_gated;

  // a request executes when the result register is free or being drained
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload of the request register needs no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tdata[CMD_W-1:0];
      in_pos <= s_tdata[CMD_W +: POS_W];
      in_val <= s_tdata[CMD_W+POS_W +: VAL_W];
    end
  end

  ple_ctrl u_ctrl (
    .cmd      (in_cmd),
    .position (in_pos),
    .count    (count),
    .op       (op)
  );

  // the store only changes when the request actually executes
  always_comb begin
    op_gated     = op;
    op_gated.ins = op.ins && fire;
    op_gated.rem = op.rem && fire;
  end

  ple_store u_store (
    .clk        (clk),
    .rst        (rst),
    .en         (fire),
    .op         (op_gated),
    .value      (in_val),
    .count      (count),
    .count_next (count_next),
    .rd_data    (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_value  <= op.rd ? rd_data : '0;
      res_count  <= count_next;
      res_status <= op.status;
    end
  end

  assign m_tdata = OUT_TW'({res_status, res_count, res_value});

`ifndef ASSERT_OFF
  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  // a full status is only reported with a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_status == ST_FULL) |-> res_count == CNT_W'(CAPACITY))
    else $error("full status with free slots");

  // an empty status is only reported with an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_status == ST_EMPTY) |-> res_count == '0)
    else $error("empty status with stored elements");

  // a failed request leaves the count unchanged
  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    fire && (op.status != ST_OK) |=> $stable(count))
    else $error("failed request changed the count");
`endif

endmodule

>>> tb/positional_list_engine_core_tb.sv
// testbench of the positional list engine: random and directed requests checked by a scoreboard
`timescale 1ns / 100ps

module positional_list_engine_core_tb;
  import ple_pkg::*;

  // command code 7 has no enum member: it must act as a no-op
  localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    status_t          status;
  } list_result_t;

  // keeps its own copy of the list and the results still owed by the block
  class list_scoreboard;
    logic [VAL_W-1:0] words [CAPACITY];
    int unsigned      word_count;
    list_result_t     owed_results [$];
    int               errors;

    function new();
      word_count = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // predict the result of one accepted request and update the list copy
    function void note_request(logic [IN_TW-1:0] data);
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;
      int unsigned      at;
      int unsigned      i;
      list_result_t     res;
      cmd = data[CMD_W-1:0];
      pos = data[CMD_W +: POS_W];
      val = data[CMD_W+POS_W +: VAL_W];
      res.value = '0;
      res.status = ST_OK;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
          at = (cmd == CMD_PUSH_FRONT) ? 0 : (cmd == CMD_PUSH_BACK) ? word_count : pos;
          if (at > word_count) begin
            res.status = ST_BADPOS;
          end else if (word_count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            for (i = word_count; i > at; i--) words[i] = words[i-1];
            words[at] = val;
            word_count++;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE_AT, CMD_READ_AT: begin
          if (word_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            at = (cmd == CMD_POP_FRONT) ? 0 : (cmd == CMD_POP_BACK) ? word_count - 1 : pos;
            if (at >= word_count) begin
              res.status = ST_BADPOS;
            end else begin
              res.value = words[at];
              if (cmd != CMD_READ_AT) begin
                for (i = at; i + 1 < word_count; i++) words[i] = words[i+1];
                word_count--;
              end
            end
          end
        end
        default: ;
      endcase
      res.count = word_count[CNT_W-1:0];
      owed_results.push_back(res);
    endfunction

    // compare one accepted result with the oldest owed one
    function void check_result(logic [OUT_TW-1:0] data);
      list_result_t exp;
      logic [VAL_W-1:0] got_value;
      logic [CNT_W-1:0] got_count;
      logic [ST_W-1:0]  got_status;
      got_value = data[VAL_W-1:0];
      got_count = data[VAL_W +: CNT_W];
      got_status = data[VAL_W+CNT_W +: ST_W];
      if (owed_results.size() == 0) begin
        $error("result with no request waiting: %h", data);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (got_value !== exp.value) begin
        $error("result_value: expected %0d, got %0d", $signed(exp.value), $signed(got_value));
        errors++;
      end
      if (got_count !== exp.count) begin
        $error("count: expected %0d, got %0d", exp.count, got_count);
        errors++;
      end
      if (got_status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got_status);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_TW-1:0]  s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_TW-1:0] m_tdata;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  list_scoreboard sb;

  positional_list_engine_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // note accepted requests before checking results of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // hand one request to the block, with random idle cycles before it
  task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TW-IN_W){1'b0}}, val, pos, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold off the sender until every owed result has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // random requests that drift between filling and draining the list
  task automatic run_random_phase(input int n);
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    int unsigned      r;
    bit               growing;
    growing = 1'b1;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(39) == 0) growing = !growing;
      // steer away from a list that stays pinned at one end
      if (sb.word_count >= CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
      if (sb.word_count == 0 && $urandom_range(3) == 0) growing = 1'b1;
      r = $urandom_range(99);
      if (r < 2) begin
        cmd = CMD_NOP;
      end else if (r < 20) begin
        cmd = CMD_READ_AT;
      end else if ((r < 65) == growing) begin
        case ($urandom_range(2))
          0: cmd = CMD_PUSH_FRONT;
          1: cmd = CMD_PUSH_BACK;
          default: cmd = CMD_INSERT_AT;
        endcase
      end else begin
        case ($urandom_range(2))
          0: cmd = CMD_POP_FRONT;
          1: cmd = CMD_POP_BACK;
          default: cmd = CMD_REMOVE_AT;
        endcase
      end
      // mostly positions near the valid range, some anywhere in the field
      if ($urandom_range(4) == 0) pos = POS_W'($urandom_range(31));
      else pos = POS_W'($urandom_range(sb.word_count));
      issue_request(cmd, pos, pick_value());
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 68;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: every removal or read reports empty, no-op stays ok
    issue_request(CMD_POP_FRONT, 0, '0);
    issue_request(CMD_POP_BACK, 0, '0);
    issue_request(CMD_REMOVE_AT, 0, '0);
    issue_request(CMD_READ_AT, 31, '0);
    issue_request(CMD_NOP, 31, '1);
    // insert beyond the count
    issue_request(CMD_INSERT_AT, 1, 32'h1234_5678);
    issue_request(CMD_INSERT_AT, 31, '1);
    // ends, middle, and insert at the count
    issue_request(CMD_INSERT_AT, 0, VAL_MIN);
    issue_request(CMD_PUSH_BACK, 0, VAL_MAX);
    issue_request(CMD_PUSH_FRONT, 31, '0);
    issue_request(CMD_INSERT_AT, 1, '1);
    issue_request(CMD_INSERT_AT, 4, 32'h5a5a_a5a5);
    issue_request(CMD_READ_AT, 2, '0);
    issue_request(CMD_READ_AT, 5, '0);
    issue_request(CMD_REMOVE_AT, 31, '0);
    issue_request(CMD_REMOVE_AT, 1, '0);
    issue_request(CMD_POP_FRONT, 0, '0);
    issue_request(CMD_POP_BACK, 0, '0);
    wait_for_results();
    // fill to capacity, then push, insert at the count and beyond it
    while (sb.word_count < CAPACITY) issue_request(CMD_PUSH_BACK, 0, $urandom);
    issue_request(CMD_PUSH_FRONT, 0, '1);
    issue_request(CMD_PUSH_BACK, 0, '1);
    issue_request(CMD_INSERT_AT, POS_W'(CAPACITY), '1);
    issue_request(CMD_INSERT_AT, POS_W'(CAPACITY + 1), '1);
    issue_request(CMD_READ_AT, POS_W'(CAPACITY - 1), '0);
    issue_request(CMD_REMOVE_AT, POS_W'(CAPACITY - 1), '0);

    run_random_phase(400);
    wait_for_results();
    send_idle_pct = 68;
    recv_idle_pct = 30;
    run_random_phase(400);
    wait_for_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(400);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> positional_list_engine_core.f
design/ple_pkg.sv
design/ple_ctrl.sv
design/ple_store.sv
design/positional_list_engine_core.sv
tb/positional_list_engine_core_tb.sv
